/* rtl/core/sha256c_pkg.sv */
// ----------------------------------------------------------------------------
// sha256c_pkg
// shared types, constants and rotr for the sha-256 compression rounds
// ----------------------------------------------------------------------------
package sha256c_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 64;

  typedef logic [WordWidth-1:0]                 word_t;
  typedef logic [$clog2(Rounds)-1:0]            round_t;
  typedef logic [$clog2(HashWords)-1:0]         pos_t;
  // element 0 is a / H0
  typedef logic [HashWords-1:0][WordWidth-1:0]  hash_t;

  localparam pos_t   LastPos   = pos_t'(HashWords - 1);
  localparam round_t LastRound = round_t'(Rounds - 1);

  localparam hash_t InitialHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundConst [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // status from the digest buffer back to the round control
  typedef struct packed {
    logic free;   // buffer can take a new digest this cycle
  } buf_status_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordWidth - n));
  endfunction

endpackage

/* rtl/core/sha256_compression_rounds.sv */
// ----------------------------------------------------------------------------
// sha256_compression_rounds
// sha-256 compression, one round per schedule word, digest out per chunk
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, schedule_word, new_message | into block
//  out     | out_valid, out_stall, digest_word,            | out of block
//          | word_position, last_word                      |
//
//  one schedule word is taken per cycle, but in_stall holds the input while
//  the 256-bit chain add after round 63 is pending; a word goes into an input
//  register and runs its round once no chain add is pending; the eight digest
//  words leave one per cycle while out_stall is low from a shift buffer, so an
//  output stall only holds the input once a further chain add finds it full
//  synchronous reset clears control, sets the chain value to the initial hash
// ----------------------------------------------------------------------------
module sha256_compression_rounds (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] schedule_word,
  input  logic        new_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_position,
  output logic        last_word
);
  import sha256c_pkg::*;

  // input register
  logic  s1_valid;
  word_t s1_word;
  logic  s1_fresh;

  // round state
  hash_t  chain;
  hash_t  work;
  round_t round;
  logic   fold_pending;   // round 63 done, chain add still to come

  hash_t       round_src;
  hash_t       round_res;
  hash_t       chain_sum;
  logic        advance;
  logic        fold;
  logic        in_take;
  buf_status_t buf_status;

  // a word may run its round unless the chain add is still waiting
  assign advance  = s1_valid && !fold_pending;
  assign in_stall = s1_valid && fold_pending;
  assign in_take  = in_valid && !in_stall;
  assign fold     = fold_pending && buf_status.free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word  <= schedule_word;
      s1_fresh <= new_message;
    end
  end

  // round 0 loads a..h from the chain value, or the initial hash on a new message
  always_comb begin
    if (round == '0) begin
      round_src = s1_fresh ? InitialHash : chain;
    end else begin
      round_src = work;
    end
  end

  sha256c_round u_round (
    .vars      (round_src),
    .sched     (s1_word),
    .kconst    (RoundConst[round]),
    .vars_next (round_res)
  );

  always_comb begin
    for (int i = 0; i < HashWords; i++) begin
      chain_sum[i] = chain[i] + work[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round        <= '0;
      fold_pending <= 1'b0;
      chain        <= InitialHash;
    end else begin
      if (advance) begin
        round <= round + round_t'(1);
        if (round == LastRound) begin
          fold_pending <= 1'b1;
        end
        if (round == '0 && s1_fresh) begin
          chain <= InitialHash;
        end
      end else if (fold) begin
        fold_pending <= 1'b0;
        chain        <= chain_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      work <= round_res;
    end
  end

  sha256c_digest_out u_digest_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fold),
    .digest        (chain_sum),
    .status        (buf_status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .digest_word   (digest_word),
    .word_position (word_position),
    .last_word     (last_word)
  );

endmodule

/* rtl/core/sha256c_round.sv */
// ----------------------------------------------------------------------------
// sha256c_round
// one sha-256 round: t1, t2 and the rotation of the working words
// ----------------------------------------------------------------------------
module sha256c_round (
  input  sha256c_pkg::hash_t vars,
  input  sha256c_pkg::word_t sched,
  input  sha256c_pkg::word_t kconst,
  output sha256c_pkg::hash_t vars_next
);
  import sha256c_pkg::*;

  word_t s1, ch, s0, maj, t1, t2;

  always_comb begin
    s1  = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1  = vars[7] + s1 + ch + kconst + sched;
    s0  = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2  = s0 + maj;

    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + t2;
  end

endmodule

/* rtl/core/sha256c_digest_out.sv */
// ----------------------------------------------------------------------------
// sha256c_digest_out
// holds one finished digest and shifts it out a word at a time
// ----------------------------------------------------------------------------
module sha256c_digest_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  sha256c_pkg::hash_t          digest,
  output sha256c_pkg::buf_status_t    status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sha256c_pkg::word_t          digest_word,
  output logic [2:0]                  word_position,
  output logic                        last_word
);
  import sha256c_pkg::*;

  hash_t words;
  pos_t  pos;
  logic  busy;
  logic  take;

  assign take        = busy && !out_stall;
  assign status.free = !busy || (take && pos == LastPos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (take) begin
      pos <= pos + pos_t'(1);
      if (pos == LastPos) begin
        busy <= 1'b0;
      end
    end
  end

  // payload shift register, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      words <= digest;
    end else if (take) begin
      for (int i = 0; i < HashWords - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  assign out_valid     = busy;
  assign digest_word   = words[0];
  assign word_position = pos;
  assign last_word     = (pos == LastPos);

endmodule
